@@ sv/fcull_pkg.sv @@
package fcull_pkg;

  localparam int NUM_PLANES = 6;
  localparam int OP_W       = 3;
  localparam int IDX_W      = 3;
  localparam int COORD_W    = 32;
  localparam int SIZE_W     = 31;
  localparam int HALF_W     = SIZE_W - 1;
  localparam int VERT_W     = COORD_W + 1;
  localparam int PROD_W     = COORD_W + VERT_W;
  localparam int SUM_W      = PROD_W + 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD      = 3'd0,
    OP_POINT     = 3'd1,
    OP_SPH_IN    = 3'd2,
    OP_SPH_ISECT = 3'd3,
    OP_BOX_IN    = 3'd4,
    OP_BOX_ISECT = 3'd5
  } op_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] d;
  } plane_t;

  // reset normals as signs: 01 = +one, 11 = -one, 00 = zero; slot 0 is rightmost
  localparam logic [NUM_PLANES-1:0][1:0] RST_NX = {2'b00, 2'b00, 2'b11, 2'b01, 2'b00, 2'b00};
  localparam logic [NUM_PLANES-1:0][1:0] RST_NY = {2'b00, 2'b00, 2'b00, 2'b00, 2'b01, 2'b11};
  localparam logic [NUM_PLANES-1:0][1:0] RST_NZ = {2'b11, 2'b01, 2'b00, 2'b00, 2'b00, 2'b00};

  function automatic logic is_test(input logic [OP_W-1:0] op);
    logic r;
    case (op)
      OP_POINT, OP_SPH_IN, OP_SPH_ISECT, OP_BOX_IN, OP_BOX_ISECT: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_box(input logic [OP_W-1:0] op);
    logic r;
    case (op)
      OP_BOX_IN, OP_BOX_ISECT: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/fcull_plane_bank.sv @@
module fcull_plane_bank #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          we,
  input  logic [fcull_pkg::IDX_W-1:0]                   idx,
  input  fcull_pkg::plane_t                             wdata,
  output fcull_pkg::plane_t [fcull_pkg::NUM_PLANES-1:0] planes
);

  localparam int CW = fcull_pkg::COORD_W;

  fcull_pkg::plane_t [fcull_pkg::NUM_PLANES-1:0] planes_r;

  function automatic logic [CW-1:0] unit(input logic [1:0] s);
    logic [CW-1:0] v;
    v = {{(CW-2){s[1]}}, s};
    return v << FRAC_BITS;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < fcull_pkg::NUM_PLANES; k++) begin
        planes_r[k].nx <= unit(fcull_pkg::RST_NX[k]);
        planes_r[k].ny <= unit(fcull_pkg::RST_NY[k]);
        planes_r[k].nz <= unit(fcull_pkg::RST_NZ[k]);
        planes_r[k].d  <= unit(2'b01);
      end
    end else if (we && (idx < fcull_pkg::IDX_W'(fcull_pkg::NUM_PLANES))) begin
      planes_r[idx] <= wdata;
    end
  end

  assign planes = planes_r;

endmodule

@@ sv/fcull_lane.sv @@
module fcull_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  fcull_pkg::plane_t                    plane,
  input  logic signed [fcull_pkg::COORD_W-1:0] cx,
  input  logic signed [fcull_pkg::COORD_W-1:0] cy,
  input  logic signed [fcull_pkg::COORD_W-1:0] cz,
  input  logic        [fcull_pkg::HALF_W-1:0]  hx,
  input  logic        [fcull_pkg::HALF_W-1:0]  hy,
  input  logic        [fcull_pkg::HALF_W-1:0]  hz,
  input  fcull_pkg::op_t                       op,
  input  logic signed [fcull_pkg::COORD_W-1:0] w,
  output logic                                 pass
);

  localparam int CW = fcull_pkg::COORD_W;
  localparam int VW = fcull_pkg::VERT_W;
  localparam int PW = fcull_pkg::PROD_W;
  localparam int SW = fcull_pkg::SUM_W;

  function automatic logic signed [VW-1:0] pick(
    input logic signed [CW-1:0]               c,
    input logic        [fcull_pkg::HALF_W-1:0] h,
    input logic                               take_hi
  );
    logic signed [VW-1:0] ce;
    logic signed [VW-1:0] he;
    ce = VW'(c);
    he = $signed({{(VW-fcull_pkg::HALF_W){1'b0}}, h});
    return take_hi ? (ce + he) : (ce - he);
  endfunction

  logic signed [VW-1:0] px, py, pz, qx, qy, qz;
  logic signed [PW-1:0] mpx, mpy, mpz, mqx, mqy, mqz;
  logic signed [PW-1:0] ppx_r, ppy_r, ppz_r, pqx_r, pqy_r, pqz_r;
  logic signed [CW-1:0] d_r;
  logic signed [SW-1:0] sp, sq, thr;

  // p-vertex: max corner where the normal component is non-negative
  assign px = pick(cx, hx, !plane.nx[CW-1]);
  assign py = pick(cy, hy, !plane.ny[CW-1]);
  assign pz = pick(cz, hz, !plane.nz[CW-1]);
  assign qx = pick(cx, hx, plane.nx[CW-1]);
  assign qy = pick(cy, hy, plane.ny[CW-1]);
  assign qz = pick(cz, hz, plane.nz[CW-1]);

  assign mpx = $signed(plane.nx) * px;
  assign mpy = $signed(plane.ny) * py;
  assign mpz = $signed(plane.nz) * pz;
  assign mqx = $signed(plane.nx) * qx;
  assign mqy = $signed(plane.ny) * qy;
  assign mqz = $signed(plane.nz) * qz;

  always_ff @(posedge clk) begin
    if (en) begin
      ppx_r <= mpx >>> FRAC_BITS;
      ppy_r <= mpy >>> FRAC_BITS;
      ppz_r <= mpz >>> FRAC_BITS;
      pqx_r <= mqx >>> FRAC_BITS;
      pqy_r <= mqy >>> FRAC_BITS;
      pqz_r <= mqz >>> FRAC_BITS;
      d_r   <= plane.d;
    end
  end

  assign sp = SW'(ppx_r) + SW'(ppy_r) + SW'(ppz_r) + SW'(d_r);
  assign sq = SW'(pqx_r) + SW'(pqy_r) + SW'(pqz_r) + SW'(d_r);

  always_comb begin
    case (op)
      fcull_pkg::OP_SPH_IN:    thr = SW'(w);
      fcull_pkg::OP_SPH_ISECT: thr = -SW'(w);
      default:                 thr = '0;
    endcase
  end

  assign pass = (sp >= thr) && ((op != fcull_pkg::OP_BOX_IN) || !sq[SW-1]);

endmodule

@@ sv/frustum_cull_test_top.sv @@
// Pipeline: an accepted test word passes through the input, product and result registers to out_valid.
// Throughput: one word per cycle while out_ready does not stall the pipeline; a plane load gives no result.
// Plane loads to indices below NUM_PLANES take effect for every test word accepted after them; others are ignored.
// Synchronous active-low reset empties the pipeline and restores the unit-cube planes.
module frustum_cull_test_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic        [fcull_pkg::OP_W-1:0]    in_opcode,
  input  logic        [fcull_pkg::IDX_W-1:0]   in_plane_index,
  input  logic signed [fcull_pkg::COORD_W-1:0] in_vec_x,
  input  logic signed [fcull_pkg::COORD_W-1:0] in_vec_y,
  input  logic signed [fcull_pkg::COORD_W-1:0] in_vec_z,
  input  logic signed [fcull_pkg::COORD_W-1:0] in_scalar_w,
  input  logic        [fcull_pkg::SIZE_W-1:0]  in_size_x,
  input  logic        [fcull_pkg::SIZE_W-1:0]  in_size_y,
  input  logic        [fcull_pkg::SIZE_W-1:0]  in_size_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_passes
);

  localparam int NP = fcull_pkg::NUM_PLANES;
  localparam int CW = fcull_pkg::COORD_W;
  localparam int HW = fcull_pkg::HALF_W;

  logic en_a, en_b, en_c;
  logic in_acc, ld_we, box_in;

  logic                 a_v_r;
  fcull_pkg::op_t       a_op_r;
  logic signed [CW-1:0] a_x_r, a_y_r, a_z_r, a_w_r;
  logic        [HW-1:0] a_hx_r, a_hy_r, a_hz_r;

  logic                 b_v_r;
  fcull_pkg::op_t       b_op_r;
  logic signed [CW-1:0] b_w_r;

  logic                 out_valid_r;
  logic                 out_passes_r;

  fcull_pkg::plane_t [NP-1:0] planes;
  fcull_pkg::plane_t          ld_plane;
  logic [NP-1:0]              lane_pass;

  assign en_c     = !out_valid_r || out_ready;
  assign en_b     = !b_v_r || en_c;
  assign en_a     = !a_v_r || en_b;
  assign in_ready = en_a;
  assign in_acc   = in_valid && in_ready;
  assign ld_we    = in_acc && (fcull_pkg::op_t'(in_opcode) == fcull_pkg::OP_LOAD);
  assign box_in   = fcull_pkg::is_box(in_opcode);

  assign ld_plane.nx = in_vec_x;
  assign ld_plane.ny = in_vec_y;
  assign ld_plane.nz = in_vec_z;
  assign ld_plane.d  = in_scalar_w;

  fcull_plane_bank #(
    .FRAC_BITS(FRAC_BITS)
  ) u_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .we     (ld_we),
    .idx    (in_plane_index),
    .wdata  (ld_plane),
    .planes (planes)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en_a) begin
      a_v_r <= in_valid && fcull_pkg::is_test(in_opcode);
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_op_r <= fcull_pkg::op_t'(in_opcode);
      a_x_r  <= in_vec_x;
      a_y_r  <= in_vec_y;
      a_z_r  <= in_vec_z;
      a_w_r  <= in_scalar_w;
      a_hx_r <= box_in ? in_size_x[fcull_pkg::SIZE_W-1:1] : '0;
      a_hy_r <= box_in ? in_size_y[fcull_pkg::SIZE_W-1:1] : '0;
      a_hz_r <= box_in ? in_size_z[fcull_pkg::SIZE_W-1:1] : '0;
    end
  end

  genvar k;
  generate
    for (k = 0; k < NP; k++) begin : g_lane
      fcull_lane #(
        .FRAC_BITS(FRAC_BITS)
      ) u_lane (
        .clk   (clk),
        .en    (en_b),
        .plane (planes[k]),
        .cx    (a_x_r),
        .cy    (a_y_r),
        .cz    (a_z_r),
        .hx    (a_hx_r),
        .hy    (a_hy_r),
        .hz    (a_hz_r),
        .op    (b_op_r),
        .w     (b_w_r),
        .pass  (lane_pass[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en_b) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_op_r <= a_op_r;
      b_w_r  <= a_w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_c) begin
      out_valid_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      out_passes_r <= &lane_pass;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_passes = out_passes_r;

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !fcull_pkg::is_test(in_opcode)) |=> !a_v_r)
    else $error("load or unused opcode entered the pipeline");

  a_test_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && fcull_pkg::is_test(in_opcode)) |=> a_v_r)
    else $error("accepted test word lost at input register");

  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_v_r && !en_b) |=> (b_v_r && $stable(b_op_r) && $stable(b_w_r)))
    else $error("product stage changed while stalled");

  a_bubble_out: assert property (@(posedge clk) disable iff (!rst_n)
    (!b_v_r && en_c) |=> !out_valid_r)
    else $error("result word without a test word");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && b_v_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken with full pipeline");

endmodule
